// ----- rtl/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the single-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

   // command codes carried by req_type
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_RESET = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   // presence result codes
   localparam logic [1:0] PRES_OK    = 2'd0;
   localparam logic [1:0] PRES_NONE  = 2'd1;
   localparam logic [1:0] PRES_FAULT = 2'd2;

   // control register indexes
   localparam logic [2:0] REG_RESET_LOW    = 3'd0;
   localparam logic [2:0] REG_PRES_WAIT    = 3'd1;
   localparam logic [2:0] REG_PRES_LIMIT   = 3'd2;
   localparam logic [2:0] REG_WR1_LOW      = 3'd3;
   localparam logic [2:0] REG_WR1_HIGH     = 3'd4;
   localparam logic [2:0] REG_WR0_LOW      = 3'd5;
   localparam logic [2:0] REG_WR0_HIGH     = 3'd6;
   localparam logic [2:0] REG_RD_LOW       = 3'd7;

   // register reset values
   localparam logic [9:0] RST_RESET_LOW  = 10'd750;
   localparam logic [9:0] RST_PRES_WAIT  = 10'd100;
   localparam logic [9:0] RST_PRES_LIMIT = 10'd240;
   localparam logic [7:0] RST_WR1_LOW    = 8'd8;
   localparam logic [7:0] RST_WR1_HIGH   = 8'd58;
   localparam logic [7:0] RST_WR0_LOW    = 8'd70;
   localparam logic [7:0] RST_WR0_HIGH   = 8'd5;
   localparam logic [7:0] RST_RD_LOW     = 8'd10;

   // fixed slot timing
   localparam logic [9:0] RELEASE_TICKS = 10'd15;
   localparam logic [9:0] SAMPLE_TICKS  = 10'd2;
   localparam logic [9:0] RECOVER_TICKS = 10'd45;

   typedef enum logic [9:0] {
      PH_IDLE       = 10'b00_0000_0001,
      PH_RST_LOW    = 10'b00_0000_0010,
      PH_RST_REL    = 10'b00_0000_0100,
      PH_PRES_HIGH  = 10'b00_0000_1000,
      PH_PRES_LOW   = 10'b00_0001_0000,
      PH_WR_LOW     = 10'b00_0010_0000,
      PH_WR_HIGH    = 10'b00_0100_0000,
      PH_RD_LOW     = 10'b00_1000_0000,
      PH_RD_WAIT    = 10'b01_0000_0000,
      PH_RD_RECOVER = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [9:0] presence_wait_ticks;
      logic [9:0] presence_low_limit;
      logic [7:0] write_one_low_ticks;
      logic [7:0] write_one_high_ticks;
      logic [7:0] write_zero_low_ticks;
      logic [7:0] write_zero_high_ticks;
      logic [7:0] read_low_ticks;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic [1:0] presence_status;
      logic       rejected;
   } result_type;

endpackage

// ----- rtl/one_wire_master_slot_timing_top.sv -----
// ----------------------------------------------------------------------------
// one_wire_master_slot_timing_top
// Single-wire bus master paced by one-microsecond tick words.
// ----------------------------------------------------------------------------
// Takes one word per clock while results are taken and returns one result word
// for each. A word is registered on entry, stepped through the slot sequencer
// once the result register is free, and lands in the result register, which
// offers it on rsp_valid; the result register holds while
// rsp_ready is low and the input register fills behind it. Timing registers
// are written through the csr channel, which is always ready; write them only
// while no command runs.
module one_wire_master_slot_timing_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_write_data,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_drive_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data,
   output logic [1:0] rsp_presence_status,
   output logic       rsp_rejected,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_data
);
   import owm_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_type_ff;
   logic [7:0] in_wdata_ff;
   logic       in_line_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_result;
   cfg_type    cfg;
   logic       step;
   logic       req_take;

   assign csr_ready = 1'b1;
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   owm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   owm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req_type   (in_type_ff),
      .write_data (in_wdata_ff),
      .line_level (in_line_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff  <= req_type;
         in_wdata_ff <= req_write_data;
         in_line_ff  <= req_line_level;
      end
      if (step) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_drive_low       = out_ff.drive_low;
   assign rsp_busy_res        = out_ff.busy_res;
   assign rsp_done_res        = out_ff.done_res;
   assign rsp_read_data       = out_ff.read_data;
   assign rsp_presence_status = out_ff.presence_status;
   assign rsp_rejected        = out_ff.rejected;

endmodule

// ----- rtl/owm_csr.sv -----
// ----------------------------------------------------------------------------
// owm_csr
// Timing control registers, written through the csr word channel.
// ----------------------------------------------------------------------------
module owm_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  logic [2:0]      wr_index,
   input  logic [9:0]      wr_data,
   output owm_pkg::cfg_type cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_RESET_LOW:  cfg_in.reset_low_ticks       = wr_data;
            REG_PRES_WAIT:  cfg_in.presence_wait_ticks   = wr_data;
            REG_PRES_LIMIT: cfg_in.presence_low_limit    = wr_data;
            REG_WR1_LOW:    cfg_in.write_one_low_ticks   = wr_data[7:0];
            REG_WR1_HIGH:   cfg_in.write_one_high_ticks  = wr_data[7:0];
            REG_WR0_LOW:    cfg_in.write_zero_low_ticks  = wr_data[7:0];
            REG_WR0_HIGH:   cfg_in.write_zero_high_ticks = wr_data[7:0];
            REG_RD_LOW:     cfg_in.read_low_ticks        = wr_data[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= RST_RESET_LOW;
         cfg_ff.presence_wait_ticks   <= RST_PRES_WAIT;
         cfg_ff.presence_low_limit    <= RST_PRES_LIMIT;
         cfg_ff.write_one_low_ticks   <= RST_WR1_LOW;
         cfg_ff.write_one_high_ticks  <= RST_WR1_HIGH;
         cfg_ff.write_zero_low_ticks  <= RST_WR0_LOW;
         cfg_ff.write_zero_high_ticks <= RST_WR0_HIGH;
         cfg_ff.read_low_ticks        <= RST_RD_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/owm_core.sv -----
// ----------------------------------------------------------------------------
// owm_core
// Slot sequencer: phase, tick counter, bit index and shift byte, advanced
// once per stepped word.
// ----------------------------------------------------------------------------
module owm_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [1:0]         req_type,
   input  logic [7:0]         write_data,
   input  logic               line_level,
   input  owm_pkg::cfg_type   cfg,
   output owm_pkg::result_type result
);
   import owm_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [9:0] tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [1:0] pres_ff, pres_in;

   logic [9:0] limit;
   logic [9:0] tick_inc;
   logic       reached;
   logic       done;
   logic       rej;
   logic [7:0] rdata;

   // count limit for the current phase
   always_comb begin
      case (phase_ff)
         PH_RST_LOW:    limit = cfg.reset_low_ticks;
         PH_RST_REL:    limit = RELEASE_TICKS;
         PH_PRES_HIGH:  limit = cfg.presence_wait_ticks;
         PH_PRES_LOW:   limit = cfg.presence_low_limit;
         PH_WR_LOW:     limit = shift_ff[0] ? {2'b00, cfg.write_one_low_ticks}
                                            : {2'b00, cfg.write_zero_low_ticks};
         PH_WR_HIGH:    limit = shift_ff[0] ? {2'b00, cfg.write_one_high_ticks}
                                            : {2'b00, cfg.write_zero_high_ticks};
         PH_RD_LOW:     limit = {2'b00, cfg.read_low_ticks};
         PH_RD_WAIT:    limit = SAMPLE_TICKS;
         PH_RD_RECOVER: limit = RECOVER_TICKS;
         default:       limit = 10'd1;
      endcase
   end

   assign tick_inc = tick_ff + 10'd1;
   assign reached  = (tick_inc >= limit);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      done     = 1'b0;
      rej      = 1'b0;
      rdata    = 8'd0;

      if (req_type != REQ_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            tick_in = 10'd0;
            bit_in  = 3'd0;
            case (req_type)
               REQ_RESET: phase_in = PH_RST_LOW;
               REQ_WRITE: begin
                  shift_in = write_data;
                  phase_in = PH_WR_LOW;
               end
               default: begin
                  shift_in = 8'd0;
                  phase_in = PH_RD_LOW;
               end
            endcase
         end
      end else begin
         case (phase_ff)
            PH_RST_LOW: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) phase_in = PH_RST_REL;
            end
            PH_RST_REL: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) phase_in = PH_PRES_HIGH;
            end
            PH_PRES_HIGH: begin
               if (line_level) begin
                  tick_in = reached ? 10'd0 : tick_inc;
                  if (reached) begin
                     pres_in  = PRES_NONE;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end else if (cfg.presence_low_limit <= 10'd1) begin
                  // first low tick already meets the limit
                  tick_in  = 10'd0;
                  pres_in  = PRES_FAULT;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  tick_in  = 10'd1;
                  phase_in = PH_PRES_LOW;
               end
            end
            PH_PRES_LOW: begin
               if (line_level) begin
                  tick_in  = 10'd0;
                  pres_in  = PRES_OK;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  tick_in = reached ? 10'd0 : tick_inc;
                  if (reached) begin
                     pres_in  = PRES_FAULT;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
            end
            PH_WR_LOW: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) phase_in = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  if (bit_ff == 3'd7) begin
                     bit_in   = 3'd0;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_WR_LOW;
                  end
               end
            end
            PH_RD_LOW: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) phase_in = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) begin
                  shift_in = shift_ff | ({7'd0, line_level} << bit_ff);
                  phase_in = PH_RD_RECOVER;
               end
            end
            PH_RD_RECOVER: begin
               tick_in = reached ? 10'd0 : tick_inc;
               if (reached) begin
                  if (bit_ff == 3'd7) begin
                     bit_in   = 3'd0;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                     rdata    = shift_ff;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_RD_LOW;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 10'd0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         pres_ff  <= PRES_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
      end
   end

   assign result.drive_low       = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                                   (phase_in == PH_RD_LOW);
   assign result.busy_res        = (phase_in != PH_IDLE);
   assign result.done_res        = done;
   assign result.read_data       = rdata;
   assign result.presence_status = pres_in;
   assign result.rejected        = rej;

endmodule

// ----- rtl/owm_checker.sv -----
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks on the single-wire bus master result words.
// ----------------------------------------------------------------------------
module owm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_drive_low,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data,
   input logic [1:0] rsp_presence_status,
   input logic       rsp_rejected
);
   import owm_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_res) &&
      $stable(rsp_read_data) && $stable(rsp_drive_low))
      else $error("result word changed while stalled");

   // a finished command leaves the bus released and the master idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_drive_low)
      else $error("done reported while still busy");

   // pulling the bus low only happens inside a command
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("bus driven low while idle");

   // read data shows only on the word that finishes a command
   a_rdata_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != 8'd0) |-> rsp_done_res && !rsp_rejected)
      else $error("read data outside a finishing word");

   // a rejected command never ends one and presence codes stay legal
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && !rsp_done_res &&
      (rsp_presence_status != (PRES_FAULT + 2'd1)))
      else $error("rejected word inconsistent");

endmodule

bind one_wire_master_slot_timing_top owm_checker u_owm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_drive_low       (rsp_drive_low),
   .rsp_busy_res        (rsp_busy_res),
   .rsp_done_res        (rsp_done_res),
   .rsp_read_data       (rsp_read_data),
   .rsp_presence_status (rsp_presence_status),
   .rsp_rejected        (rsp_rejected)
);

// ----- tb/tb_one_wire_master_slot_timing_top.sv -----
// ----------------------------------------------------------------------------
// tb_one_wire_master_slot_timing_top
// Self-checking bench for the single-wire bus master. Tick and command words
// with scripted or random line levels are sent through the request channel.
// Each result word is predicted from a bench copy of the slot sequencer and
// compared field by field. Both channels stall at random, and the timing
// registers go through reset, short, zero and random settings.
// ----------------------------------------------------------------------------
module tb_one_wire_master_slot_timing_top;
   import owm_pkg::*;

   // in a correct run no word stays still long enough to reach this limit
   localparam int IDLE_LIMIT = 2000;

   typedef enum int {LINE_NOISE, LINE_UP, LINE_DOWN, LINE_PULSE} line_shape_type;

   typedef struct {
      req_code_type kind;
      logic [7:0]   value;
      logic         line;
   } bus_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = REQ_TICK;
   logic [7:0] req_write_data = 8'h00;
   logic       req_line_level = 1'b1;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_drive_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_data;
   logic [1:0] rsp_presence_status;
   logic       rsp_rejected;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = REG_RESET_LOW;
   logic [9:0] csr_data = 10'd0;

   bus_word_type words_to_send[$];
   result_type   bus_results_due[$];
   int           words_queued = 0;
   int           errors = 0;
   int           idle_cycles = 0;
   int           send_gap = 0;
   int           take_gap = 0;
   bit           calm = 1'b0;

   // bench copy of the timing registers and of the sequencer state
   logic [9:0] timing[8];
   phase_type  bus_phase = PH_IDLE;
   logic [9:0] slot_ticks = 10'd0;
   logic [2:0] slot_bit = 3'd0;
   logic [7:0] slot_shift = 8'h00;
   logic [1:0] pres_code = PRES_OK;

   one_wire_master_slot_timing_top dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // a register at zero times out like one
   function automatic int span_of(logic [9:0] ticks);
      return (ticks == 10'd0) ? 1 : int'(ticks);
   endfunction

   function automatic logic count_reaches(logic [9:0] limit);
      slot_ticks = slot_ticks + 10'd1;
      if (slot_ticks >= limit) begin
         slot_ticks = 10'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic result_type step_bus_master(req_code_type cmd, logic [7:0] value,
                                                  logic line);
      result_type res;
      logic       one;
      res = '0;
      if (cmd != REQ_TICK) begin
         if (bus_phase != PH_IDLE) begin
            res.rejected = 1'b1;
         end else begin
            slot_ticks = 10'd0;
            slot_bit   = 3'd0;
            case (cmd)
               REQ_RESET: bus_phase = PH_RST_LOW;
               REQ_WRITE: begin
                  slot_shift = value;
                  bus_phase  = PH_WR_LOW;
               end
               default: begin
                  slot_shift = 8'h00;
                  bus_phase  = PH_RD_LOW;
               end
            endcase
         end
      end else begin
         case (bus_phase)
            PH_RST_LOW: begin
               if (count_reaches(timing[REG_RESET_LOW])) bus_phase = PH_RST_REL;
            end
            PH_RST_REL: begin
               if (count_reaches(RELEASE_TICKS)) bus_phase = PH_PRES_HIGH;
            end
            PH_PRES_HIGH: begin
               if (line) begin
                  if (count_reaches(timing[REG_PRES_WAIT])) begin
                     pres_code    = PRES_NONE;
                     bus_phase    = PH_IDLE;
                     res.done_res = 1'b1;
                  end
               end else begin
                  // first low tick already counts toward the fault limit
                  slot_ticks = 10'd0;
                  bus_phase  = PH_PRES_LOW;
                  if (count_reaches(timing[REG_PRES_LIMIT])) begin
                     pres_code    = PRES_FAULT;
                     bus_phase    = PH_IDLE;
                     res.done_res = 1'b1;
                  end
               end
            end
            PH_PRES_LOW: begin
               if (line) begin
                  slot_ticks   = 10'd0;
                  pres_code    = PRES_OK;
                  bus_phase    = PH_IDLE;
                  res.done_res = 1'b1;
               end else if (count_reaches(timing[REG_PRES_LIMIT])) begin
                  pres_code    = PRES_FAULT;
                  bus_phase    = PH_IDLE;
                  res.done_res = 1'b1;
               end
            end
            PH_WR_LOW: begin
               one = slot_shift[0];
               if (count_reaches(one ? timing[REG_WR1_LOW] : timing[REG_WR0_LOW]))
                  bus_phase = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
               one = slot_shift[0];
               if (count_reaches(one ? timing[REG_WR1_HIGH] : timing[REG_WR0_HIGH])) begin
                  slot_shift = slot_shift >> 1;
                  if (slot_bit == 3'd7) begin
                     slot_bit     = 3'd0;
                     bus_phase    = PH_IDLE;
                     res.done_res = 1'b1;
                  end else begin
                     slot_bit  = slot_bit + 3'd1;
                     bus_phase = PH_WR_LOW;
                  end
               end
            end
            PH_RD_LOW: begin
               if (count_reaches(timing[REG_RD_LOW])) bus_phase = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
               if (count_reaches(SAMPLE_TICKS)) begin
                  slot_shift[slot_bit] = slot_shift[slot_bit] | line;
                  bus_phase            = PH_RD_RECOVER;
               end
            end
            PH_RD_RECOVER: begin
               if (count_reaches(RECOVER_TICKS)) begin
                  if (slot_bit == 3'd7) begin
                     slot_bit      = 3'd0;
                     bus_phase     = PH_IDLE;
                     res.done_res  = 1'b1;
                     res.read_data = slot_shift;
                  end else begin
                     slot_bit  = slot_bit + 3'd1;
                     bus_phase = PH_RD_LOW;
                  end
               end
            end
            default: ;
         endcase
      end
      res.drive_low       = (bus_phase == PH_RST_LOW) || (bus_phase == PH_WR_LOW) ||
                            (bus_phase == PH_RD_LOW);
      res.busy_res        = (bus_phase != PH_IDLE);
      res.presence_status = pres_code;
      return res;
   endfunction

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic queue_word(req_code_type kind, logic [7:0] value, logic line);
      bus_word_type w;
      w.kind  = kind;
      w.value = value;
      w.line  = line;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   // a command followed by the ticks it needs, optionally cut short or with a
   // second command landing while it runs
   task automatic queue_command(req_code_type kind, logic [7:0] value,
                                line_shape_type shape, int low_run, int poke_at, bit trim);
      int           span;
      int           quiet;
      int           offset;
      int           i;
      int           b;
      logic         line;
      req_code_type other;
      span  = 0;
      quiet = span_of(timing[REG_RESET_LOW]) + int'(RELEASE_TICKS);
      case (kind)
         REQ_RESET: begin
            span = quiet + span_of(timing[REG_PRES_WAIT]) +
                   span_of(timing[REG_PRES_LIMIT]) + 2;
         end
         REQ_WRITE: begin
            for (b = 0; b < 8; b++) begin
               span += value[b] ?
                       span_of(timing[REG_WR1_LOW]) + span_of(timing[REG_WR1_HIGH]) :
                       span_of(timing[REG_WR0_LOW]) + span_of(timing[REG_WR0_HIGH]);
            end
         end
         REQ_READ: begin
            span = 8 * (span_of(timing[REG_RD_LOW]) + int'(SAMPLE_TICKS) +
                        int'(RECOVER_TICKS));
         end
         default: span = 0;
      endcase
      if (trim) span = int'($urandom_range(0, span));
      span += int'($urandom_range(0, 3));
      queue_word(kind, value, 1'($urandom));
      for (i = 0; i < span; i++) begin
         if (i == poke_at) begin
            other = req_code_type'($urandom_range(1, 3));
            queue_word(other, 8'($urandom), 1'($urandom));
         end
         if (kind == REQ_RESET && i < quiet) begin
            line = 1'($urandom);
         end else begin
            offset = (kind == REQ_RESET) ? i - quiet : i;
            case (shape)
               LINE_UP:    line = 1'b1;
               LINE_DOWN:  line = 1'b0;
               LINE_PULSE: line = (offset >= low_run);
               default:    line = 1'($urandom);
            endcase
         end
         queue_word(REQ_TICK, 8'($urandom), line);
      end
   endtask

   task automatic write_timing(logic [2:0] index, logic [9:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      timing[index] = (index >= REG_WR1_LOW) ? (value & 10'h0FF) : value;
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(logic [9:0] rst_low, logic [9:0] pres_wait,
                             logic [9:0] pres_limit, logic [9:0] wr1_low,
                             logic [9:0] wr1_high, logic [9:0] wr0_low,
                             logic [9:0] wr0_high, logic [9:0] rd_low);
      write_timing(REG_RESET_LOW, rst_low);
      write_timing(REG_PRES_WAIT, pres_wait);
      write_timing(REG_PRES_LIMIT, pres_limit);
      write_timing(REG_WR1_LOW, wr1_low);
      write_timing(REG_WR1_HIGH, wr1_high);
      write_timing(REG_WR0_LOW, wr0_low);
      write_timing(REG_WR0_HIGH, wr0_high);
      write_timing(REG_RD_LOW, rd_low);
   endtask

   // drain everything, then tick on until no command is left running
   task automatic settle();
      do begin
         // checked away from the driving edge so the driver's updates are seen
         while (words_to_send.size() != 0 || req_valid || bus_results_due.size() != 0)
            @(negedge clock);
         repeat (4) @(posedge clock);
         if (bus_phase != PH_IDLE)
            repeat (64) queue_word(REQ_TICK, 8'($urandom), 1'($urandom));
      end while (bus_phase != PH_IDLE);
   endtask

   task automatic run_random(int words);
      int           first;
      int           pick;
      req_code_type kind;
      first = words_queued;
      while (words_queued - first < words) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 8) begin
            repeat ($urandom_range(1, 5)) queue_word(REQ_TICK, 8'($urandom), 1'($urandom));
         end else begin
            kind = (pick < 45) ? REQ_RESET : (pick < 80) ? REQ_WRITE : REQ_READ;
            queue_command(kind, 8'($urandom), line_shape_type'($urandom_range(0, 3)),
                          int'($urandom_range(1, span_of(timing[REG_PRES_LIMIT]) + 1)),
                          ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 40)) : -1,
                          $urandom_range(0, 7) == 0);
         end
      end
      settle();
   endtask

   task automatic random_timing();
      set_timing(10'($urandom_range(1, 12)), 10'($urandom_range(1, 12)),
                 10'($urandom_range(1, 12)), 10'($urandom_range(1, 8)),
                 10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)),
                 10'($urandom_range(1, 8)), 10'($urandom_range(1, 6)));
   endtask

   // request side
   always @(posedge clock) begin
      bus_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            bus_results_due.push_back(step_bus_master(req_code_type'(req_type),
                                                      req_write_data, req_line_level));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
               send_gap  <= int'($urandom_range(0, 7));
               req_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
               w = words_to_send.pop_front();
               req_valid      <= 1'b1;
               req_type       <= w.kind;
               req_write_data <= w.value;
               req_line_level <= w.line;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.drive_low       = rsp_drive_low;
            seen.busy_res        = rsp_busy_res;
            seen.done_res        = rsp_done_res;
            seen.read_data       = rsp_read_data;
            seen.presence_status = rsp_presence_status;
            seen.rejected        = rsp_rejected;
            if (bus_results_due.size() == 0) begin
               $display("%0t result word with nothing expected: expected none actual %h",
                        $time, seen);
               errors++;
            end else begin
               want = bus_results_due.pop_front();
               compare_field("drive_low", 8'(want.drive_low), 8'(seen.drive_low));
               compare_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
               compare_field("done_res", 8'(want.done_res), 8'(seen.done_res));
               compare_field("read_data", want.read_data, seen.read_data);
               compare_field("presence_status", 8'(want.presence_status),
                             8'(seen.presence_status));
               compare_field("rejected", 8'(want.rejected), 8'(seen.rejected));
            end
         end
         if (take_gap != 0) begin
            take_gap  <= take_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            take_gap  <= int'($urandom_range(0, 7));
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_one_wire_master_slot_timing_top: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      timing[REG_RESET_LOW]  = RST_RESET_LOW;
      timing[REG_PRES_WAIT]  = RST_PRES_WAIT;
      timing[REG_PRES_LIMIT] = RST_PRES_LIMIT;
      timing[REG_WR1_LOW]    = 10'(RST_WR1_LOW);
      timing[REG_WR1_HIGH]   = 10'(RST_WR1_HIGH);
      timing[REG_WR0_LOW]    = 10'(RST_WR0_LOW);
      timing[REG_WR0_HIGH]   = 10'(RST_WR0_HIGH);
      timing[REG_RD_LOW]     = 10'(RST_RD_LOW);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // write slot registers at their reset values
      queue_command(REQ_WRITE, 8'hA5, LINE_NOISE, 0, -1, 1'b0);
      settle();

      // short timings, narrow registers keep their low byte: idle ticks,
      // every presence outcome, all-ones and all-zeros bytes, commands while busy
      set_timing(10'd1, 10'd3, 10'd4, 10'h301, 10'h302, 10'h303, 10'h301, 10'h301);
      queue_word(REQ_TICK, 8'h00, 1'b0);
      queue_word(REQ_TICK, 8'hFF, 1'b1);
      queue_command(REQ_RESET, 8'h00, LINE_UP, 0, -1, 1'b0);
      queue_command(REQ_RESET, 8'h00, LINE_PULSE, 2, -1, 1'b0);
      queue_command(REQ_RESET, 8'h00, LINE_DOWN, 0, 1, 1'b0);
      queue_command(REQ_WRITE, 8'hFF, LINE_NOISE, 0, 3, 1'b0);
      queue_command(REQ_WRITE, 8'h00, LINE_NOISE, 0, 5, 1'b0);
      queue_word(REQ_TICK, 8'h5A, 1'b0);
      settle();

      // all timing registers at zero
      set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      run_random(60);

      random_timing();
      run_random(60);

      // back to back on both channels
      calm = 1'b1;
      random_timing();
      run_random(60);

      repeat (10) @(posedge clock);
      if (bus_results_due.size() != 0) begin
         $display("%0t missing result words: expected %0d actual 0", $time,
                  bus_results_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb_one_wire_master_slot_timing_top: PASS");
      end else begin
         $display("tb_one_wire_master_slot_timing_top: FAIL");
      end
      $finish;
   end

endmodule
